/* hw/rtl/cmrr_pkg.sv */
// ----------------------------------------------------------------------------
// cmrr_pkg
// Shared types and constants for the CAN message reassembly ring.
// ----------------------------------------------------------------------------
`default_nettype none

package cmrr_pkg;

   localparam logic ACTION_RX   = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   localparam logic [3:0] CHUNK_BYTES    = 4'd8;
   localparam logic [4:0] LAST_CHUNK_IDX = 5'd31;

   typedef struct packed {
      logic        action;
      logic [28:0] frame_id;
      logic [3:0]  frame_len;
      logic [63:0] frame_data;
   } req_item_type;

   typedef struct packed {
      logic        msg_valid;
      logic [3:0]  board_id;
      logic [8:0]  msg_length;
      logic [63:0] chunk_data;
      logic [3:0]  chunk_bytes;
      logic        last_chunk;
   } rsp_item_type;

   typedef struct packed {
      logic load;
      logic app_step;
      logic copy_rd;
      logic copy_wr;
      logic commit;
      logic chunk_rd;
      logic chunk_wr;
      logic emit;
      logic emit_empty;
      logic release_slot;
   } cmd_type;

   typedef struct packed {
      logic req_read;
      logic req_lt;
      logic req_eq;
      logic app_done;
      logic copy_done;
      logic rd_full;
      logic byte_more;
      logic chunk_last;
      logic rsp_busy;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_APPEND_COMMIT,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_COMMIT,
      ST_CHUNK_RD,
      ST_CHUNK_WR,
      ST_CHUNK_OUT,
      ST_EMPTY
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/cmrr_ctrl.sv */
// ----------------------------------------------------------------------------
// cmrr_ctrl
// Sequencer for frame append, message commit copy and chunked slot reads.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrr_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  cmrr_pkg::status_type status,
   output cmrr_pkg::cmd_type    cmd
);

   cmrr_pkg::state_type state_ff;
   cmrr_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmrr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cmrr_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.req_read) begin
                  state_in = status.rd_full ? cmrr_pkg::ST_CHUNK_RD : cmrr_pkg::ST_EMPTY;
               end else if (status.req_lt) begin
                  state_in = cmrr_pkg::ST_APPEND;
               end else if (status.req_eq) begin
                  state_in = cmrr_pkg::ST_APPEND_COMMIT;
               end
            end
         end
         cmrr_pkg::ST_APPEND: begin
            if (status.app_done) state_in = cmrr_pkg::ST_IDLE;
         end
         cmrr_pkg::ST_APPEND_COMMIT: begin
            if (status.app_done) state_in = cmrr_pkg::ST_COPY_RD;
         end
         cmrr_pkg::ST_COPY_RD: begin
            state_in = status.copy_done ? cmrr_pkg::ST_COMMIT : cmrr_pkg::ST_COPY_WR;
         end
         cmrr_pkg::ST_COPY_WR: state_in = cmrr_pkg::ST_COPY_RD;
         cmrr_pkg::ST_COMMIT:  state_in = cmrr_pkg::ST_IDLE;
         cmrr_pkg::ST_CHUNK_RD: begin
            state_in = status.byte_more ? cmrr_pkg::ST_CHUNK_WR : cmrr_pkg::ST_CHUNK_OUT;
         end
         cmrr_pkg::ST_CHUNK_WR: state_in = cmrr_pkg::ST_CHUNK_RD;
         cmrr_pkg::ST_CHUNK_OUT: begin
            if (!status.rsp_busy) begin
               state_in = status.chunk_last ? cmrr_pkg::ST_IDLE : cmrr_pkg::ST_CHUNK_RD;
            end
         end
         cmrr_pkg::ST_EMPTY: begin
            if (!status.rsp_busy) state_in = cmrr_pkg::ST_IDLE;
         end
         default: state_in = cmrr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         cmrr_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         cmrr_pkg::ST_APPEND,
         cmrr_pkg::ST_APPEND_COMMIT: cmd.app_step = !status.app_done;
         cmrr_pkg::ST_COPY_RD:       cmd.copy_rd  = !status.copy_done;
         cmrr_pkg::ST_COPY_WR:       cmd.copy_wr  = 1'b1;
         cmrr_pkg::ST_COMMIT:        cmd.commit   = 1'b1;
         cmrr_pkg::ST_CHUNK_RD:      cmd.chunk_rd = status.byte_more;
         cmrr_pkg::ST_CHUNK_WR:      cmd.chunk_wr = 1'b1;
         cmrr_pkg::ST_CHUNK_OUT: begin
            cmd.emit         = !status.rsp_busy;
            cmd.release_slot = !status.rsp_busy && status.chunk_last;
         end
         cmrr_pkg::ST_EMPTY:         cmd.emit_empty = !status.rsp_busy;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/cmrr_datapath.sv */
// ----------------------------------------------------------------------------
// cmrr_datapath
// Assembly buffer, slot memory, ring pointers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrr_datapath #(
   parameter int MSG_SLOTS = 4,
   parameter int MSG_BYTES = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  cmrr_pkg::req_item_type req_item,
   input  cmrr_pkg::cmd_type      cmd,
   output cmrr_pkg::status_type   status,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output cmrr_pkg::rsp_item_type rsp_item
);

   localparam int PW = $clog2(MSG_SLOTS);
   localparam int AW = $clog2(MSG_BYTES);
   localparam int CW = $clog2(MSG_BYTES + 1);

   localparam logic [PW-1:0] LAST_SLOT = PW'(MSG_SLOTS - 1);
   localparam logic [CW-1:0] CNT_MAX   = CW'(MSG_BYTES);

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == LAST_SLOT) ? '0 : p + 1'b1;
   endfunction

   logic [7:0] asm_mem  [MSG_BYTES];
   logic [7:0] slot_mem [MSG_SLOTS][MSG_BYTES];
   logic [7:0] asm_rd_ff;
   logic [7:0] slot_rd_ff;

   logic [3:0]  len_ff,   len_in;
   logic [63:0] data_ff,  data_in;
   logic [3:0]  board_ff, board_in;
   logic [3:0]  k_ff,     k_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [4:0]  c_ff,     c_in;
   logic [3:0]  j_ff,     j_in;
   logic [63:0] chunk_ff, chunk_in;

   logic [CW-1:0] asm_cnt_ff, asm_cnt_in;
   logic [CW-1:0] slot_len_ff   [MSG_SLOTS];
   logic [CW-1:0] slot_len_in   [MSG_SLOTS];
   logic [3:0]    slot_board_ff [MSG_SLOTS];
   logic [3:0]    slot_board_in [MSG_SLOTS];
   logic [MSG_SLOTS-1:0] slot_full_ff, slot_full_in;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   cmrr_pkg::rsp_item_type rsp_item_ff,  rsp_item_in;

   logic [7:0]    fnum;
   logic [7:0]    ftot;
   logic [3:0]    len_clamp;
   logic          asm_full;
   logic [CW-1:0] mlen;
   logic [9:0]    mlen10;
   logic [9:0]    base10;
   logic [9:0]    rem10;
   logic [3:0]    n_bytes;
   logic          chunk_last;
   logic [AW-1:0] rd_addr;
   logic [PW-1:0] wr_next;

   assign fnum      = req_item.frame_id[7:0];
   assign ftot      = req_item.frame_id[15:8];
   assign len_clamp = (req_item.frame_len > cmrr_pkg::CHUNK_BYTES) ?
                      cmrr_pkg::CHUNK_BYTES : req_item.frame_len;
   assign asm_full  = (asm_cnt_ff == CNT_MAX);

   assign mlen       = slot_len_ff[rd_ptr_ff];
   assign mlen10     = 10'(mlen);
   assign base10     = {2'b00, c_ff, 3'b000};
   assign rem10      = (mlen10 > base10) ? (mlen10 - base10) : 10'd0;
   assign n_bytes    = (rem10 > 10'd8) ? cmrr_pkg::CHUNK_BYTES : rem10[3:0];
   assign chunk_last = (c_ff == cmrr_pkg::LAST_CHUNK_IDX) || (mlen10 <= base10 + 10'd8);
   assign rd_addr    = AW'({c_ff, j_ff[2:0]});
   assign wr_next    = ring_next(wr_ptr_ff);

   always_comb begin
      status.req_read   = (req_item.action == cmrr_pkg::ACTION_READ);
      status.req_lt     = (fnum < ftot);
      status.req_eq     = (fnum == ftot);
      status.app_done   = (k_ff == len_ff);
      status.copy_done  = (idx_ff == asm_cnt_ff);
      status.rd_full    = slot_full_ff[rd_ptr_ff];
      status.byte_more  = (j_ff != n_bytes);
      status.chunk_last = chunk_last;
      status.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (cmd.app_step && !asm_full) begin
         asm_mem[asm_cnt_ff[AW-1:0]] <= data_ff[{k_ff[2:0], 3'b000} +: 8];
      end
      if (cmd.copy_rd) begin
         asm_rd_ff <= asm_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy_wr) begin
         slot_mem[wr_ptr_ff][idx_ff[AW-1:0]] <= asm_rd_ff;
      end
      if (cmd.chunk_rd) begin
         slot_rd_ff <= slot_mem[rd_ptr_ff][rd_addr];
      end
   end

   always_comb begin
      len_in        = len_ff;
      data_in       = data_ff;
      board_in      = board_ff;
      k_in          = k_ff;
      idx_in        = idx_ff;
      c_in          = c_ff;
      j_in          = j_ff;
      chunk_in      = chunk_ff;
      asm_cnt_in    = asm_cnt_ff;
      slot_len_in   = slot_len_ff;
      slot_board_in = slot_board_ff;
      slot_full_in  = slot_full_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      rsp_item_in   = rsp_item_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         len_in   = len_clamp;
         data_in  = req_item.frame_data;
         board_in = req_item.frame_id[27:24];
         k_in     = '0;
         idx_in   = '0;
         c_in     = '0;
         j_in     = '0;
         chunk_in = '0;
      end
      if (cmd.app_step) begin
         k_in = k_ff + 4'd1;
         if (!asm_full) asm_cnt_in = asm_cnt_ff + 1'b1;
      end
      if (cmd.copy_wr) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.commit) begin
         slot_len_in[wr_ptr_ff]   = asm_cnt_ff;
         slot_board_in[wr_ptr_ff] = board_ff;
         slot_full_in[wr_ptr_ff]  = 1'b1;
         wr_ptr_in                = wr_next;
         if (wr_next == rd_ptr_ff) rd_ptr_in = ring_next(rd_ptr_ff);
         asm_cnt_in               = '0;
      end
      if (cmd.chunk_wr) begin
         chunk_in[{j_ff[2:0], 3'b000} +: 8] = slot_rd_ff;
         j_in = j_ff + 4'd1;
      end
      if (cmd.emit) begin
         rsp_item_in.msg_valid    = 1'b1;
         rsp_item_in.board_id     = slot_board_ff[rd_ptr_ff];
         rsp_item_in.msg_length   = 9'(mlen);
         rsp_item_in.chunk_data   = chunk_ff;
         rsp_item_in.chunk_bytes  = n_bytes;
         rsp_item_in.last_chunk   = chunk_last;
         rsp_valid_in             = 1'b1;
         c_in                     = c_ff + 5'd1;
         j_in                     = '0;
         chunk_in                 = '0;
      end
      if (cmd.emit_empty) begin
         rsp_item_in            = '0;
         rsp_item_in.last_chunk = 1'b1;
         rsp_valid_in           = 1'b1;
      end
      if (cmd.release_slot) begin
         slot_full_in[rd_ptr_ff] = 1'b0;
         slot_len_in[rd_ptr_ff]  = '0;
         rd_ptr_in               = ring_next(rd_ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         asm_cnt_ff    <= '0;
         slot_len_ff   <= '{default: '0};
         slot_board_ff <= '{default: '0};
         slot_full_ff  <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         asm_cnt_ff    <= asm_cnt_in;
         slot_len_ff   <= slot_len_in;
         slot_board_ff <= slot_board_in;
         slot_full_ff  <= slot_full_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      data_ff     <= data_in;
      board_ff    <= board_in;
      k_ff        <= k_in;
      idx_ff      <= idx_in;
      c_ff        <= c_in;
      j_ff        <= j_in;
      chunk_ff    <= chunk_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

/* hw/rtl/can_message_reassembly_ring.sv */
// ----------------------------------------------------------------------------
// can_message_reassembly_ring
// Reassembles multi-frame CAN messages into a ring of message slots and
// returns queued messages as 8-byte chunks.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall cmrr_pkg::req_item_type
//   rsp      out        rsp_valid/rsp_stall cmrr_pkg::rsp_item_type
//
// Frame: appends frame_len bytes (lengths above 8 count as 8), or is ignored;
// a final frame then copies the message into its slot byte by byte.
// Read: gathers and emits each chunk in turn; an empty slot gives one beat.
// Synchronous reset clears pointers, slot flags and lengths; memories keep data.
// A stalled result holds in the output register; the block accepts the next
// item meanwhile and waits only when it must load another result.
// ----------------------------------------------------------------------------
`default_nettype none

module can_message_reassembly_ring #(
   parameter int MSG_SLOTS = 4,
   parameter int MSG_BYTES = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  cmrr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output cmrr_pkg::rsp_item_type rsp_item
);

   cmrr_pkg::cmd_type    cmd;
   cmrr_pkg::status_type status;

   cmrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cmrr_datapath #(
      .MSG_SLOTS (MSG_SLOTS),
      .MSG_BYTES (MSG_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

/* hw/rtl/cmrr_checker.sv */
// ----------------------------------------------------------------------------
// cmrr_checker
// Port-level checks for the CAN message reassembly ring.
// ----------------------------------------------------------------------------
`default_nettype none

module cmrr_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input cmrr_pkg::req_item_type req_item,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input cmrr_pkg::rsp_item_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result beat changed");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.msg_valid |->
         rsp_item.last_chunk && rsp_item.chunk_bytes == 4'd0 &&
         rsp_item.msg_length == 9'd0 && rsp_item.chunk_data == 64'd0 &&
         rsp_item.board_id == 4'd0)
      else $error("empty-slot beat not all zero with last flag");

   a_full_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last_chunk |->
         rsp_item.msg_valid && rsp_item.chunk_bytes == cmrr_pkg::CHUNK_BYTES)
      else $error("non-final chunk not a full valid chunk");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_item.action == cmrr_pkg::ACTION_READ |=> req_stall)
      else $error("read beat did not occupy the block");

endmodule

bind can_message_reassembly_ring cmrr_checker u_cmrr_checker (.*);

`default_nettype wire
